### hdl/wsml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsml_pkg
// Shared sizes, register map and the tag that travels with each element read
// during the window scan.
// ----------------------------------------------------------------------------
package wsml_pkg;

    localparam int MAX_SIZE     = 64;
    localparam int ELEMENT_BITS = 16;
    localparam int SUM_BITS     = 28;
    localparam int POS_BITS     = $clog2(MAX_SIZE);
    localparam int ADDR_BITS    = 2 * POS_BITS;
    localparam int CFG_BITS     = 7;
    localparam int DATA_BITS    = 32;
    localparam int PADDR_BITS   = 3;

    localparam logic [CFG_BITS-1:0] MATRIX_SIZE_RESET = CFG_BITS'(6);
    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = CFG_BITS'(3);

    typedef enum logic {
        REG_MATRIX_SIZE = 1'b0,
        REG_WINDOW_SIZE = 1'b1
    } t_reg_idx;

    // tag of one element read while scanning
    typedef struct packed {
        logic                first;     // first element of its window
        logic                last;      // last element of its window
        logic                win_first; // window at the top-left corner
        logic                final_win; // last element of the last window
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
    } t_rd_tag;

    // force a register value into 1..MAX_SIZE
    function automatic logic [CFG_BITS-1:0] clamp_size(input logic [CFG_BITS-1:0] v);
        logic [CFG_BITS-1:0] r;
        if (v == '0) begin
            r = CFG_BITS'(1);
        end else if (v > CFG_BITS'(MAX_SIZE)) begin
            r = CFG_BITS'(MAX_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hdl/wsml_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsml_acc
// Shared accumulator and compare unit: sums the elements of one window as
// they stream in, then compares the sum against the running max and min.
// ----------------------------------------------------------------------------
module wsml_acc (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_clear,
    input  logic                                  i_vld,
    input  wsml_pkg::t_rd_tag                     i_tag,
    input  logic signed [wsml_pkg::ELEMENT_BITS-1:0] i_data,
    output logic                                  o_done,
    output logic signed [wsml_pkg::SUM_BITS-1:0]  o_max_sum,
    output logic [wsml_pkg::POS_BITS-1:0]         o_max_row,
    output logic [wsml_pkg::POS_BITS-1:0]         o_max_col,
    output logic signed [wsml_pkg::SUM_BITS-1:0]  o_min_sum,
    output logic [wsml_pkg::POS_BITS-1:0]         o_min_row,
    output logic [wsml_pkg::POS_BITS-1:0]         o_min_col
);

    logic signed [wsml_pkg::SUM_BITS-1:0] r_acc;
    logic signed [wsml_pkg::SUM_BITS-1:0] n_acc;
    logic signed [wsml_pkg::SUM_BITS-1:0] w_ext;
    wsml_pkg::t_rd_tag                    r_sum_tag;
    logic                                 r_sum_vld;
    logic                                 r_done;
    logic signed [wsml_pkg::SUM_BITS-1:0] r_max_sum;
    logic signed [wsml_pkg::SUM_BITS-1:0] r_min_sum;
    logic [wsml_pkg::POS_BITS-1:0]        r_max_row;
    logic [wsml_pkg::POS_BITS-1:0]        r_max_col;
    logic [wsml_pkg::POS_BITS-1:0]        r_min_row;
    logic [wsml_pkg::POS_BITS-1:0]        r_min_col;

    assign w_ext = {{(wsml_pkg::SUM_BITS - wsml_pkg::ELEMENT_BITS){i_data[wsml_pkg::ELEMENT_BITS-1]}},
                    i_data};

    always_comb begin
        n_acc = (i_tag.first ? '0 : r_acc) + w_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_acc <= n_acc;
        end
        if (i_vld && i_tag.last) begin
            r_sum_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
            r_done    <= 1'b0;
            r_max_sum <= '0;
            r_min_sum <= '0;
            r_max_row <= '0;
            r_max_col <= '0;
            r_min_row <= '0;
            r_min_col <= '0;
        end else begin
            r_sum_vld <= i_vld && i_tag.last;
            r_done    <= r_sum_vld && r_sum_tag.final_win;
            if (i_clear) begin
                r_max_sum <= '0;
                r_min_sum <= '0;
                r_max_row <= '0;
                r_max_col <= '0;
                r_min_row <= '0;
                r_min_col <= '0;
            end else if (r_sum_vld) begin
                // ties keep the earlier window
                if (r_sum_tag.win_first || r_acc > r_max_sum) begin
                    r_max_sum <= r_acc;
                    r_max_row <= r_sum_tag.row;
                    r_max_col <= r_sum_tag.col;
                end
                if (r_sum_tag.win_first || r_acc < r_min_sum) begin
                    r_min_sum <= r_acc;
                    r_min_row <= r_sum_tag.row;
                    r_min_col <= r_sum_tag.col;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_max_sum = r_max_sum;
    assign o_max_row = r_max_row;
    assign o_max_col = r_max_col;
    assign o_min_sum = r_min_sum;
    assign o_min_row = r_min_row;
    assign o_min_col = r_min_col;

endmodule

### hdl/window_sum_max_min_locator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_sum_max_min_locator_core
// Stores an n-by-n matrix one element per accepted item, then scans every
// k-by-k window with one shared accumulator and reports max and min sums.
// ----------------------------------------------------------------------------
// Load: one element per cycle, busy stays low until the last element.
// Scan: one element read from the matrix RAM per cycle into the single
// accumulator, then a drain state until the accumulator is done; busy high.
// If k > n the invalid result strobes the cycle after the last element.
// o_done is high for one cycle when the result is on the ports; it cannot stall.
// Synchronous reset clears control and results; sizes reset to 6 and 3.
module window_sum_max_min_locator_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [wsml_pkg::PADDR_BITS-1:0]          paddr,
    input  logic [wsml_pkg::DATA_BITS-1:0]           pwdata,
    output logic [wsml_pkg::DATA_BITS-1:0]           prdata,
    output logic                                     pready,
    input  logic                                     i_start,
    output logic                                     o_busy,
    input  logic signed [wsml_pkg::ELEMENT_BITS-1:0] i_element_value,
    output logic                                     o_done,
    output logic                                     o_result_valid,
    output logic signed [wsml_pkg::SUM_BITS-1:0]     o_max_sum,
    output logic [wsml_pkg::POS_BITS-1:0]            o_max_row,
    output logic [wsml_pkg::POS_BITS-1:0]            o_max_col,
    output logic signed [wsml_pkg::SUM_BITS-1:0]     o_min_sum,
    output logic [wsml_pkg::POS_BITS-1:0]            o_min_row,
    output logic [wsml_pkg::POS_BITS-1:0]            o_min_col
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN
    } t_state;

    typedef wsml_pkg::t_reg_idx t_reg_sel;

    t_state                              r_state;
    logic [wsml_pkg::CFG_BITS-1:0]       r_matrix_size;
    logic [wsml_pkg::CFG_BITS-1:0]       r_window_size;
    logic [wsml_pkg::CFG_BITS-1:0]       w_n;
    logic [wsml_pkg::CFG_BITS-1:0]       w_k;
    logic [wsml_pkg::POS_BITS-1:0]       w_nm1;
    logic [wsml_pkg::POS_BITS-1:0]       w_km1;
    logic [wsml_pkg::POS_BITS-1:0]       w_lim;
    logic                                w_cfg_wr;
    t_reg_sel                            w_sel;
    logic                                w_accept;
    logic                                w_load_last;

    // load position and scan counters
    logic [wsml_pkg::POS_BITS-1:0]       r_ld_row;
    logic [wsml_pkg::POS_BITS-1:0]       r_ld_col;
    logic [wsml_pkg::POS_BITS-1:0]       r_wr;
    logic [wsml_pkg::POS_BITS-1:0]       r_wc;
    logic [wsml_pkg::POS_BITS-1:0]       r_ir;
    logic [wsml_pkg::POS_BITS-1:0]       r_ic;

    logic                                r_result_valid;
    logic                                r_inv_done;
    logic                                w_clear;
    logic                                r_s1_vld;
    wsml_pkg::t_rd_tag                   r_s1_tag;
    wsml_pkg::t_rd_tag                   w_tag;
    logic                                w_ic_end;
    logic                                w_ir_end;
    logic                                w_wc_end;
    logic                                w_wr_end;
    logic                                w_acc_done;

    logic signed [wsml_pkg::ELEMENT_BITS-1:0] r_mem [2**wsml_pkg::ADDR_BITS];
    logic signed [wsml_pkg::ELEMENT_BITS-1:0] r_rdata;
    logic [wsml_pkg::ADDR_BITS-1:0]           w_raddr;
    logic [wsml_pkg::POS_BITS-1:0]            w_rrow;
    logic [wsml_pkg::POS_BITS-1:0]            w_rcol;

    assign w_n   = wsml_pkg::clamp_size(r_matrix_size);
    assign w_k   = wsml_pkg::clamp_size(r_window_size);
    assign w_nm1 = wsml_pkg::POS_BITS'(w_n - 1'b1);
    assign w_km1 = wsml_pkg::POS_BITS'(w_k - 1'b1);
    assign w_lim = wsml_pkg::POS_BITS'(w_n - w_k);

    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_sel    = t_reg_sel'(paddr[2]);
    assign pready   = 1'b1;

    always_comb begin
        unique case (w_sel)
            wsml_pkg::REG_MATRIX_SIZE: prdata = wsml_pkg::DATA_BITS'(r_matrix_size);
            wsml_pkg::REG_WINDOW_SIZE: prdata = wsml_pkg::DATA_BITS'(r_window_size);
            default:                   prdata = '0;
        endcase
    end

    assign o_busy      = (r_state != S_LOAD);
    assign w_accept    = i_start && !o_busy;
    assign w_load_last = (r_ld_row == w_nm1) && (r_ld_col == w_nm1);

    // clear the results together with the invalid strobe
    assign w_clear = w_accept && w_load_last && (w_k > w_n);

    assign w_ic_end = (r_ic == w_km1);
    assign w_ir_end = (r_ir == w_km1);
    assign w_wc_end = (r_wc == w_lim);
    assign w_wr_end = (r_wr == w_lim);

    always_comb begin
        w_tag.first     = (r_ir == '0) && (r_ic == '0);
        w_tag.last      = w_ic_end && w_ir_end;
        w_tag.win_first = (r_wr == '0) && (r_wc == '0);
        w_tag.final_win = w_ic_end && w_ir_end && w_wc_end && w_wr_end;
        w_tag.row       = r_wr;
        w_tag.col       = r_wc;
    end

    assign w_rrow  = r_wr + r_ir;
    assign w_rcol  = r_wc + r_ic;
    assign w_raddr = {w_rrow, w_rcol};

    // matrix RAM: row-major at row * MAX_SIZE + col
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[{r_ld_row, r_ld_col}] <= i_element_value;
        end
        r_rdata <= r_mem[w_raddr];
        r_s1_tag <= w_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_matrix_size  <= wsml_pkg::MATRIX_SIZE_RESET;
            r_window_size  <= wsml_pkg::WINDOW_SIZE_RESET;
            r_ld_row       <= '0;
            r_ld_col       <= '0;
            r_wr           <= '0;
            r_wc           <= '0;
            r_ir           <= '0;
            r_ic           <= '0;
            r_result_valid <= 1'b0;
            r_inv_done     <= 1'b0;
            r_s1_vld       <= 1'b0;
        end else begin
            r_inv_done <= 1'b0;
            r_s1_vld   <= (r_state == S_SCAN);
            if (w_cfg_wr) begin
                unique case (w_sel)
                    wsml_pkg::REG_MATRIX_SIZE: r_matrix_size <= pwdata[wsml_pkg::CFG_BITS-1:0];
                    wsml_pkg::REG_WINDOW_SIZE: r_window_size <= pwdata[wsml_pkg::CFG_BITS-1:0];
                    default: ;
                endcase
                // restart the load
                r_ld_row <= '0;
                r_ld_col <= '0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_load_last) begin
                            r_ld_row <= '0;
                            r_ld_col <= '0;
                            if (w_k > w_n) begin
                                r_result_valid <= 1'b0;
                                r_inv_done     <= 1'b1;
                            end else begin
                                r_result_valid <= 1'b1;
                                r_wr           <= '0;
                                r_wc           <= '0;
                                r_ir           <= '0;
                                r_ic           <= '0;
                                r_state        <= S_SCAN;
                            end
                        end else if (r_ld_col == w_nm1) begin
                            r_ld_col <= '0;
                            r_ld_row <= r_ld_row + 1'b1;
                        end else begin
                            r_ld_col <= r_ld_col + 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    // advance column, row, window column, window row
                    if (!w_ic_end) begin
                        r_ic <= r_ic + 1'b1;
                    end else begin
                        r_ic <= '0;
                        if (!w_ir_end) begin
                            r_ir <= r_ir + 1'b1;
                        end else begin
                            r_ir <= '0;
                            if (!w_wc_end) begin
                                r_wc <= r_wc + 1'b1;
                            end else begin
                                r_wc <= '0;
                                if (!w_wr_end) begin
                                    r_wr <= r_wr + 1'b1;
                                end else begin
                                    r_state <= S_DRAIN;
                                end
                            end
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_acc_done) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    wsml_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_vld     (r_s1_vld),
        .i_tag     (r_s1_tag),
        .i_data    (r_rdata),
        .o_done    (w_acc_done),
        .o_max_sum (o_max_sum),
        .o_max_row (o_max_row),
        .o_max_col (o_max_col),
        .o_min_sum (o_min_sum),
        .o_min_row (o_min_row),
        .o_min_col (o_min_col)
    );

    assign o_done         = w_acc_done || r_inv_done;
    assign o_result_valid = r_result_valid;

endmodule

### tb/window_sum_max_min_locator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_sum_max_min_locator_core_tb
// Loads square matrices through the start/busy port and checks every max/min
// window report against a brute-force scanner in the bench or a value in the
// directed table, which covers size clamping, oversize windows, load restart
// and sum extremes; random phases then sweep sizes, data patterns and gaps.
// ----------------------------------------------------------------------------
module window_sum_max_min_locator_core_tb;

    localparam logic [wsml_pkg::PADDR_BITS-1:0] MATRIX_SIZE_ADDR =
        wsml_pkg::PADDR_BITS'(wsml_pkg::REG_MATRIX_SIZE) << 2;
    localparam logic [wsml_pkg::PADDR_BITS-1:0] WINDOW_SIZE_ADDR =
        wsml_pkg::PADDR_BITS'(wsml_pkg::REG_WINDOW_SIZE) << 2;
    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic                                 ok;
        logic signed [wsml_pkg::SUM_BITS-1:0] hi_sum;
        logic [wsml_pkg::POS_BITS-1:0]        hi_row;
        logic [wsml_pkg::POS_BITS-1:0]        hi_col;
        logic signed [wsml_pkg::SUM_BITS-1:0] lo_sum;
        logic [wsml_pkg::POS_BITS-1:0]        lo_row;
        logic [wsml_pkg::POS_BITS-1:0]        lo_col;
    } t_window_report;

    typedef enum logic {
        ROW_CFG,
        ROW_ELEM
    } t_row_kind;

    typedef struct {
        t_row_kind                                kind;
        logic [wsml_pkg::PADDR_BITS-1:0]          addr;
        logic [wsml_pkg::DATA_BITS-1:0]           data;
        logic signed [wsml_pkg::ELEMENT_BITS-1:0] value;
        bit                                       typed;
        t_window_report                           want;
    } t_stim_row;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n;
    logic                                     psel;
    logic                                     penable;
    logic                                     pwrite;
    logic [wsml_pkg::PADDR_BITS-1:0]          paddr;
    logic [wsml_pkg::DATA_BITS-1:0]           pwdata;
    logic [wsml_pkg::DATA_BITS-1:0]           prdata;
    logic                                     pready;
    logic                                     i_start;
    logic                                     o_busy;
    logic signed [wsml_pkg::ELEMENT_BITS-1:0] i_element_value;
    logic                                     o_done;
    logic                                     o_result_valid;
    logic signed [wsml_pkg::SUM_BITS-1:0]     o_max_sum;
    logic [wsml_pkg::POS_BITS-1:0]            o_max_row;
    logic [wsml_pkg::POS_BITS-1:0]            o_max_col;
    logic signed [wsml_pkg::SUM_BITS-1:0]     o_min_sum;
    logic [wsml_pkg::POS_BITS-1:0]            o_min_row;
    logic [wsml_pkg::POS_BITS-1:0]            o_min_col;

    // scanner state, mirrors the block
    logic signed [wsml_pkg::ELEMENT_BITS-1:0] elem_store [wsml_pkg::MAX_SIZE*wsml_pkg::MAX_SIZE];
    int                                       fill_count;
    logic [wsml_pkg::CFG_BITS-1:0]            side_reg;
    logic [wsml_pkg::CFG_BITS-1:0]            win_reg;

    t_window_report pending_reports [$];
    t_window_report head_report;
    int             items_taken;
    int             quiet_cycles;
    bit             failed;

    window_sum_max_min_locator_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_element_value (i_element_value),
        .o_done          (o_done),
        .o_result_valid  (o_result_valid),
        .o_max_sum       (o_max_sum),
        .o_max_row       (o_max_row),
        .o_max_col       (o_max_col),
        .o_min_sum       (o_min_sum),
        .o_min_row       (o_min_row),
        .o_min_col       (o_min_col)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int fit_side(input logic [wsml_pkg::CFG_BITS-1:0] v);
        int s;
        s = int'(v);
        if (s == 0) begin
            s = 1;
        end else if (s > wsml_pkg::MAX_SIZE) begin
            s = wsml_pkg::MAX_SIZE;
        end
        return s;
    endfunction

    function automatic t_window_report make_report(input bit ok, input longint hs,
                                                   input int hr, input int hc,
                                                   input longint ls, input int lr,
                                                   input int lc);
        t_window_report rep;
        rep.ok     = ok;
        rep.hi_sum = wsml_pkg::SUM_BITS'(hs);
        rep.hi_row = wsml_pkg::POS_BITS'(hr);
        rep.hi_col = wsml_pkg::POS_BITS'(hc);
        rep.lo_sum = wsml_pkg::SUM_BITS'(ls);
        rep.lo_row = wsml_pkg::POS_BITS'(lr);
        rep.lo_col = wsml_pkg::POS_BITS'(lc);
        return rep;
    endfunction

    // brute-force scan of every window; the first window seeds both extremes
    function automatic t_window_report scan_windows_report();
        t_window_report rep;
        int     side;
        int     win;
        longint acc;
        longint top;
        longint bot;
        int     top_r;
        int     top_c;
        int     bot_r;
        int     bot_c;
        bit     seen;
        rep   = '0;
        side  = fit_side(side_reg);
        win   = fit_side(win_reg);
        seen  = 1'b0;
        top   = 0;
        bot   = 0;
        top_r = 0;
        top_c = 0;
        bot_r = 0;
        bot_c = 0;
        if (win > side) begin
            return rep;
        end
        for (int r = 0; r + win <= side; r++) begin
            for (int c = 0; c + win <= side; c++) begin
                acc = 0;
                for (int i = 0; i < win; i++) begin
                    for (int j = 0; j < win; j++) begin
                        acc += elem_store[(r + i) * side + c + j];
                    end
                end
                if (!seen || acc > top) begin
                    top   = acc;
                    top_r = r;
                    top_c = c;
                end
                if (!seen || acc < bot) begin
                    bot   = acc;
                    bot_r = r;
                    bot_c = c;
                end
                seen = 1'b1;
            end
        end
        return make_report(1'b1, top, top_r, top_c, bot, bot_r, bot_c);
    endfunction

    function automatic bit absorb_element(input logic signed [wsml_pkg::ELEMENT_BITS-1:0] v,
                                          output t_window_report rep);
        int total;
        total = fit_side(side_reg) * fit_side(side_reg);
        rep   = '0;
        if (fill_count >= total) begin
            fill_count = 0;
        end
        elem_store[fill_count] = v;
        fill_count++;
        if (fill_count < total) begin
            return 1'b0;
        end
        fill_count = 0;
        rep = scan_windows_report();
        return 1'b1;
    endfunction

    function automatic t_stim_row cfg_row(input logic [wsml_pkg::PADDR_BITS-1:0] addr,
                                          input logic [wsml_pkg::DATA_BITS-1:0] data);
        t_stim_row row;
        row.kind  = ROW_CFG;
        row.addr  = addr;
        row.data  = data;
        row.value = '0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_stim_row elem_row(input logic signed [wsml_pkg::ELEMENT_BITS-1:0] v,
                                           input bit typed, input t_window_report want);
        t_stim_row row;
        row.kind  = ROW_ELEM;
        row.addr  = '0;
        row.data  = '0;
        row.value = v;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic logic signed [wsml_pkg::ELEMENT_BITS-1:0] pick_element(
        input int flavor, input int fixed_val);
        logic signed [wsml_pkg::ELEMENT_BITS-1:0] v;
        case (flavor)
            0:       v = wsml_pkg::ELEMENT_BITS'($urandom_range(0, 65535));
            1:       v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2:       v = wsml_pkg::ELEMENT_BITS'($urandom_range(0, 2) - 1);
            default: v = wsml_pkg::ELEMENT_BITS'(fixed_val);
        endcase
        return v;
    endfunction

    // expects to be called right after a rising edge
    task automatic apb_access(input logic wr, input logic [wsml_pkg::PADDR_BITS-1:0] addr,
                              input logic [wsml_pkg::DATA_BITS-1:0] wdata,
                              output logic [wsml_pkg::DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input logic [wsml_pkg::PADDR_BITS-1:0] addr,
                             input logic [wsml_pkg::DATA_BITS-1:0] data);
        logic [wsml_pkg::DATA_BITS-1:0] unused;
        apb_access(1'b1, addr, data, unused);
        case (wsml_pkg::t_reg_idx'(addr >> 2))
            wsml_pkg::REG_MATRIX_SIZE: side_reg = data[wsml_pkg::CFG_BITS-1:0];
            wsml_pkg::REG_WINDOW_SIZE: win_reg  = data[wsml_pkg::CFG_BITS-1:0];
            default: ;
        endcase
        fill_count = 0;
    endtask

    task automatic check_reset_reg(input logic [wsml_pkg::PADDR_BITS-1:0] addr,
                                   input logic [wsml_pkg::CFG_BITS-1:0] want);
        logic [wsml_pkg::DATA_BITS-1:0] rd;
        apb_access(1'b0, addr, '0, rd);
        if (rd !== wsml_pkg::DATA_BITS'(want)) begin
            $display("%0t: reset value at 0x%0h mismatch: expected %0d, got %0d",
                     $time, addr, want, rd);
            failed = 1'b1;
        end
    endtask

    // hold start low until every report is in, then let the block go quiet
    task automatic settle_block();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic feed(input logic signed [wsml_pkg::ELEMENT_BITS-1:0] v, input bit typed,
                        input t_window_report want);
        t_window_report rep;
        bit calm;
        calm = (items_taken >= 300 && items_taken < 450);
        while (!calm && $urandom_range(0, 99) < 27) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (o_busy);
        items_taken++;
        if (absorb_element(v, rep)) begin
            pending_reports.push_back(typed ? want : rep);
        end
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: report with no matrix pending: expected none, got max %0d min %0d",
                         $time, o_max_sum, o_min_sum);
                failed = 1'b1;
            end else begin
                head_report = pending_reports.pop_front();
                check_field("result_valid", head_report.ok, o_result_valid);
                check_field("max_sum", head_report.hi_sum, o_max_sum);
                check_field("max_row", head_report.hi_row, o_max_row);
                check_field("max_col", head_report.hi_col, o_max_col);
                check_field("min_sum", head_report.lo_sum, o_min_sum);
                check_field("min_row", head_report.lo_row, o_min_row);
                check_field("min_col", head_report.lo_col, o_min_col);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start === 1'b1 && o_busy === 1'b0) || o_done === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item or report for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_stim_row plan [$];
        int        random_goal;
        int        side;
        int        n_val;
        int        k_val;
        int        mats;
        int        flavor;
        int        fixed_val;
        int        extra;
        logic [wsml_pkg::DATA_BITS-1:0] n_word;
        logic [wsml_pkg::DATA_BITS-1:0] k_word;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_start         <= 1'b0;
        i_element_value <= '0;
        quiet_cycles    <= 0;
        failed      = 1'b0;
        items_taken = 0;
        fill_count  = 0;
        side_reg    = wsml_pkg::MATRIX_SIZE_RESET;
        win_reg     = wsml_pkg::WINDOW_SIZE_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reset_reg(MATRIX_SIZE_ADDR, wsml_pkg::MATRIX_SIZE_RESET);
        check_reset_reg(WINDOW_SIZE_ADDR, wsml_pkg::WINDOW_SIZE_RESET);

        // directed: 1x1 extremes, zero sizes, window too large, 2x2 extremes,
        // ties, and a register write in the middle of a load
        plan.push_back(cfg_row(MATRIX_SIZE_ADDR, 32'hFFFF_FF81));
        plan.push_back(cfg_row(WINDOW_SIZE_ADDR, 32'h0000_0001));
        plan.push_back(elem_row(16'sh7FFF, 1'b1, make_report(1'b1, 32767, 0, 0, 32767, 0, 0)));
        plan.push_back(elem_row(16'sh8000, 1'b1,
                                make_report(1'b1, -32768, 0, 0, -32768, 0, 0)));
        plan.push_back(cfg_row(WINDOW_SIZE_ADDR, 32'h0));
        plan.push_back(cfg_row(MATRIX_SIZE_ADDR, 32'h0));
        plan.push_back(elem_row(16'sh0000, 1'b1, make_report(1'b1, 0, 0, 0, 0, 0, 0)));
        plan.push_back(cfg_row(WINDOW_SIZE_ADDR, 32'h2));
        plan.push_back(elem_row(16'sd1234, 1'b1, '0));
        plan.push_back(cfg_row(MATRIX_SIZE_ADDR, 32'h2));
        repeat (3) plan.push_back(elem_row(16'sh7FFF, 1'b0, '0));
        plan.push_back(elem_row(16'sh7FFF, 1'b1,
                                make_report(1'b1, 131068, 0, 0, 131068, 0, 0)));
        plan.push_back(cfg_row(WINDOW_SIZE_ADDR, 32'h1));
        plan.push_back(elem_row(16'sd5, 1'b0, '0));
        plan.push_back(elem_row(16'sd5, 1'b0, '0));
        plan.push_back(elem_row(-16'sd7, 1'b0, '0));
        plan.push_back(elem_row(-16'sd7, 1'b0, '0));
        plan.push_back(cfg_row(MATRIX_SIZE_ADDR, 32'h3));
        plan.push_back(cfg_row(WINDOW_SIZE_ADDR, 32'h2));
        plan.push_back(elem_row(16'sd100, 1'b0, '0));
        plan.push_back(elem_row(-16'sd100, 1'b0, '0));
        plan.push_back(cfg_row(MATRIX_SIZE_ADDR, 32'h2));
        repeat (3) plan.push_back(elem_row(16'sh8000, 1'b0, '0));
        plan.push_back(elem_row(16'sh8000, 1'b1,
                                make_report(1'b1, -131072, 0, 0, -131072, 0, 0)));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle_block();
                write_reg(plan[i].addr, plan[i].data);
            end else begin
                feed(plan[i].value, plan[i].typed, plan[i].want);
            end
        end

        // random phases of small matrices; upper write bits are noise
        random_goal = items_taken + RANDOM_ITEMS;
        while (items_taken < random_goal) begin
            n_val = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
            side  = fit_side(wsml_pkg::CFG_BITS'(n_val));
            case ($urandom_range(0, 11))
                0:       k_val = 0;
                1:       k_val = $urandom_range(65, 127);
                2:       k_val = side + $urandom_range(1, 2);
                default: k_val = $urandom_range(1, side);
            endcase
            n_word = ($urandom() & ~32'h7F) | wsml_pkg::DATA_BITS'(n_val);
            k_word = ($urandom() & ~32'h7F) | wsml_pkg::DATA_BITS'(k_val);
            settle_block();
            if ($urandom_range(0, 1)) begin
                write_reg(MATRIX_SIZE_ADDR, n_word);
                write_reg(WINDOW_SIZE_ADDR, k_word);
            end else begin
                write_reg(WINDOW_SIZE_ADDR, k_word);
                write_reg(MATRIX_SIZE_ADDR, n_word);
            end
            mats = $urandom_range(1, 4);
            for (int m = 0; m < mats; m++) begin
                flavor    = $urandom_range(0, 3);
                fixed_val = $urandom_range(0, 65535);
                for (int e = 0; e < side * side; e++) begin
                    feed(pick_element(flavor, fixed_val), 1'b0, '0);
                end
                if ($urandom_range(0, 5) == 0) begin
                    settle_block();
                end
            end
            // leave a partial load behind for the next register write to drop
            if (side > 1 && $urandom_range(0, 2) == 0) begin
                extra = $urandom_range(1, side * side - 1);
                for (int e = 0; e < extra; e++) begin
                    feed(pick_element(0, 0), 1'b0, '0);
                end
            end
        end

        // window clamped above the matrix, then a full-matrix window at the
        // negative element limit
        settle_block();
        write_reg(MATRIX_SIZE_ADDR, 32'h0000_0008);
        write_reg(WINDOW_SIZE_ADDR, 32'h0000_007F);
        for (int e = 0; e < 64; e++) begin
            feed(16'sh8000, 1'b0, '0);
        end
        settle_block();
        write_reg(WINDOW_SIZE_ADDR, 32'h0000_0008);
        for (int e = 0; e < 64; e++) begin
            feed(16'sh8000, 1'b0, '0);
        end

        i_start <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (32) @(posedge i_clk);
        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hdl/wsml_pkg.sv
hdl/wsml_acc.sv
hdl/window_sum_max_min_locator_core.sv
tb/window_sum_max_min_locator_core_tb.sv
